### rtl/lrf_pkg.sv
`default_nettype none

package lrf_pkg;

  // record layout
  localparam int MAX_PAYLOAD  = 100;
  localparam int HEADER_BYTES = 6;
  localparam int STORE_DEPTH  = HEADER_BYTES + MAX_PAYLOAD + 1;
  localparam int POS_W        = $clog2(STORE_DEPTH);

  // byte store split into eight byte-wide banks, one per lane of a word
  localparam int BANKS       = 8;
  localparam int BANK_SEL_W  = $clog2(BANKS);
  localparam int BANK_DEPTH  = (STORE_DEPTH + BANKS - 1) / BANKS;
  localparam int WORD_W      = POS_W - BANK_SEL_W;

  localparam logic [POS_W-1:0] PUT_LIMIT  = POS_W'(HEADER_BYTES + MAX_PAYLOAD);
  localparam logic [POS_W-1:0] LEN_POS    = POS_W'(HEADER_BYTES - 1);
  localparam logic [7:0]       HDR_LEN_OFS = 8'(HEADER_BYTES);

  localparam logic [7:0] HDR_MARK   = 8'h1E;
  localparam logic [7:0] CHECK_SEED = 8'hFF;
  localparam logic [7:0] OVF_BIT    = 8'h80;
  localparam logic [7:0] STR_RESET_LEN = 8'd32;

  // configuration port
  localparam int CFG_AW = 3;
  localparam logic [CFG_AW-3:0] REG_MAX_STR = '0;

  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_VALUE  = 2'd1,
    OP_STRING = 2'd2,
    OP_END    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PUT,
    ST_EMIT,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic             en;
    logic [POS_W-1:0] pos;
    logic [7:0]       data;
  } store_wr_t;

endpackage

`default_nettype wire

### rtl/log_record_framer_unit.sv
// start: five header bytes; append value: 1, 2, 4 or 8 bytes, one store write per byte
// string character: 0 to 2 bytes; end record: busy while words = wp/8+1 (1..14) are read
// after end: words leave via the read and output registers, one word per cycle (one row
// of the eight-bank byte store per read); results cannot be stalled by the receiver
// sync reset: control state cleared, max string length set to 32; store left as is
`default_nettype none

module log_record_framer_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  in_operation,
  input  logic [15:0]                 in_file_id,
  input  logic [15:0]                 in_line_number,
  input  logic [63:0]                 in_value,
  input  logic [1:0]                  in_value_size,
  input  logic [7:0]                  in_text_char,
  output logic                        out_valid,
  output logic [63:0]                 out_frame_data,
  output logic [3:0]                  out_byte_count,
  output logic                        out_last_word,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [lrf_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready
);
  import lrf_pkg::*;

  logic [7:0]        max_str_r;
  logic              cfg_wr;
  logic              cfg_hit;
  store_wr_t         st_wr;
  logic [WORD_W-1:0] st_rd_addr;
  logic [63:0]       st_rd_data;

  // register file: one register, max string length
  assign cfg_pready = 1'b1;
  assign cfg_hit    = cfg_paddr[CFG_AW-1:2] == REG_MAX_STR;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_hit;
  assign cfg_prdata = cfg_hit ? {24'd0, max_str_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_str_r <= STR_RESET_LEN;
    end else if (cfg_wr) begin
      max_str_r <= cfg_pwdata[7:0];
    end
  end

  lrf_store u_store (
    .clk    (clk),
    .wr     (st_wr),
    .rd_addr(st_rd_addr),
    .rd_data(st_rd_data)
  );

  lrf_seq u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_operation  (in_operation),
    .in_file_id    (in_file_id),
    .in_line_number(in_line_number),
    .in_value      (in_value),
    .in_value_size (in_value_size),
    .in_text_char  (in_text_char),
    .max_str_len   (max_str_r),
    .wr            (st_wr),
    .rd_addr       (st_rd_addr),
    .rd_data       (st_rd_data),
    .out_valid     (out_valid),
    .out_frame_data(out_frame_data),
    .out_byte_count(out_byte_count),
    .out_last_word (out_last_word)
  );

endmodule

`default_nettype wire

### rtl/lrf_ram.sv
`default_nettype none

module lrf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/lrf_store.sv
`default_nettype none

module lrf_store (
  input  logic                      clk,
  input  lrf_pkg::store_wr_t        wr,
  input  logic [lrf_pkg::WORD_W-1:0] rd_addr,
  output logic [63:0]               rd_data
);
  import lrf_pkg::*;

  // byte position selects lane in low bits, word row in high bits
  for (genvar b = 0; b < BANKS; b++) begin : g_bank
    logic bank_we;

    assign bank_we = wr.en && (wr.pos[BANK_SEL_W-1:0] == BANK_SEL_W'(b));

    lrf_ram #(
      .WIDTH(8),
      .DEPTH(BANK_DEPTH)
    ) u_bank (
      .clk  (clk),
      .we   (bank_we),
      .waddr(wr.pos[POS_W-1:BANK_SEL_W]),
      .wdata(wr.data),
      .raddr(rd_addr),
      .rdata(rd_data[8*b +: 8])
    );
  end

endmodule

`default_nettype wire

### rtl/lrf_seq.sv
`default_nettype none

module lrf_seq (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 in_operation,
  input  logic [15:0]                in_file_id,
  input  logic [15:0]                in_line_number,
  input  logic [63:0]                in_value,
  input  logic [1:0]                 in_value_size,
  input  logic [7:0]                 in_text_char,
  input  logic [7:0]                 max_str_len,
  output lrf_pkg::store_wr_t         wr,
  output logic [lrf_pkg::WORD_W-1:0] rd_addr,
  input  logic [63:0]                rd_data,
  output logic                       out_valid,
  output logic [63:0]                out_frame_data,
  output logic [3:0]                 out_byte_count,
  output logic                       out_last_word
);
  import lrf_pkg::*;

  state_t           state_r, state_nxt;
  logic [POS_W-1:0] wp_r, wp_nxt;
  logic [7:0]       chk_r, chk_nxt;
  logic             ovf_r, ovf_nxt;
  logic [7:0]       scnt_r, scnt_nxt;
  logic             scap_r, scap_nxt;
  logic [63:0]      put_data_r, put_data_nxt;
  logic [3:0]       put_cnt_r, put_cnt_nxt;
  logic             hdr_r, hdr_nxt;
  logic [WORD_W-1:0] issue_w_r, issue_w_nxt;
  logic [WORD_W-1:0] data_w_r;
  logic             data_v_r;
  logic             out_valid_r;
  logic [63:0]      out_data_r, out_data_nxt;
  logic [3:0]       out_cnt_r, out_cnt_nxt;
  logic             out_last_r, out_last_nxt;

  logic             accept;
  op_t              op;
  logic             put_ok;
  logic [7:0]       put_byte;
  logic             last_issue;
  logic [7:0]       len_byte;
  logic [7:0]       chk_byte;
  logic             last_data;

  // string character decode
  logic             str_take;
  logic [7:0]       str_cnt_inc;
  logic             str_cap;
  logic [3:0]       str_n;
  logic [63:0]      str_data;

  assign accept     = start && (state_r == ST_IDLE);
  assign op         = op_t'(in_operation);
  assign put_byte   = put_data_r[7:0];
  assign put_ok     = wp_r < PUT_LIMIT;
  assign last_issue = issue_w_r == wp_r[POS_W-1:BANK_SEL_W];
  assign last_data  = data_w_r == wp_r[POS_W-1:BANK_SEL_W];

  // length byte and closing check
  always_comb begin
    len_byte = {{(8 - POS_W){1'b0}}, wp_r} - HDR_LEN_OFS;
    if (ovf_r) begin
      len_byte = len_byte | OVF_BIT;
    end
    chk_byte = chk_r ^ len_byte;
  end

  // how a string character turns into bytes
  always_comb begin
    str_take    = 1'b0;
    str_cnt_inc = scnt_r;
    str_cap     = 1'b0;
    str_n       = 4'd0;
    str_data    = '0;
    if (scap_r) begin
      str_n = 4'd0;
    end else if (in_text_char == 8'd0) begin
      str_n = 4'd1;
    end else begin
      str_take = scnt_r < max_str_len;
      if (str_take) begin
        str_cnt_inc = scnt_r + 8'd1;
      end
      str_cap = str_cnt_inc >= max_str_len;
      if (str_take && str_cap) begin
        str_n    = 4'd2;
        str_data = {48'd0, 8'd0, in_text_char};
      end else if (str_take) begin
        str_n    = 4'd1;
        str_data = {56'd0, in_text_char};
      end else begin
        str_n    = 4'd1;
        str_data = '0;
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (op)
            OP_START, OP_VALUE: state_nxt = ST_PUT;
            OP_STRING:          state_nxt = (str_n != 4'd0) ? ST_PUT : ST_IDLE;
            OP_END:             state_nxt = ST_EMIT;
            default:            state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_PUT: begin
        if (put_cnt_r == 4'd1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (last_issue) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // record state and byte feed
  always_comb begin
    wp_nxt       = wp_r;
    chk_nxt      = chk_r;
    ovf_nxt      = ovf_r;
    scnt_nxt     = scnt_r;
    scap_nxt     = scap_r;
    put_data_nxt = put_data_r;
    put_cnt_nxt  = put_cnt_r;
    hdr_nxt      = hdr_r;
    issue_w_nxt  = issue_w_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (op)
            OP_START: begin
              wp_nxt       = '0;
              chk_nxt      = CHECK_SEED;
              ovf_nxt      = 1'b0;
              scnt_nxt     = '0;
              scap_nxt     = 1'b0;
              put_data_nxt = {24'd0, in_line_number, in_file_id, HDR_MARK};
              put_cnt_nxt  = 4'd5;
              hdr_nxt      = 1'b1;
            end
            OP_VALUE: begin
              put_data_nxt = in_value;
              put_cnt_nxt  = 4'd1 << in_value_size;
              hdr_nxt      = 1'b0;
            end
            OP_STRING: begin
              put_data_nxt = str_data;
              put_cnt_nxt  = str_n;
              hdr_nxt      = 1'b0;
              if (scap_r) begin
                if (in_text_char == 8'd0) begin
                  scap_nxt = 1'b0;
                  scnt_nxt = '0;
                end
              end else if (in_text_char == 8'd0) begin
                scnt_nxt = '0;
              end else begin
                scnt_nxt = str_cnt_inc;
                if (str_cap) begin
                  scap_nxt = 1'b1;
                end
              end
            end
            OP_END: begin
              issue_w_nxt = '0;
            end
            default: begin
              hdr_nxt = hdr_r;
            end
          endcase
        end
      end
      ST_PUT: begin
        put_data_nxt = {8'd0, put_data_r[63:8]};
        put_cnt_nxt  = put_cnt_r - 4'd1;
        if (put_ok) begin
          chk_nxt = chk_r ^ put_byte;
          wp_nxt  = wp_r + POS_W'(1);
        end else begin
          ovf_nxt = 1'b1;
        end
        // header skips the length byte slot
        if (hdr_r && put_cnt_r == 4'd1) begin
          wp_nxt = wp_r + POS_W'(2);
        end
      end
      ST_EMIT: begin
        issue_w_nxt = issue_w_r + WORD_W'(1);
      end
      ST_DRAIN: begin
        issue_w_nxt = issue_w_r;
      end
      default: begin
        issue_w_nxt = issue_w_r;
      end
    endcase
  end

  // word assembly from the read row
  always_comb begin
    logic [POS_W-1:0] idx;
    out_data_nxt = '0;
    for (int k = 0; k < BANKS; k++) begin
      idx = {data_w_r, BANK_SEL_W'(k)};
      if (idx == wp_r) begin
        out_data_nxt[8*k +: 8] = chk_byte;
      end else if (idx > wp_r) begin
        out_data_nxt[8*k +: 8] = 8'd0;
      end else if (idx == LEN_POS) begin
        out_data_nxt[8*k +: 8] = len_byte;
      end else begin
        out_data_nxt[8*k +: 8] = rd_data[8*k +: 8];
      end
    end
    out_last_nxt = last_data;
    out_cnt_nxt  = last_data ? ({1'b0, wp_r[BANK_SEL_W-1:0]} + 4'd1) : 4'(BANKS);
  end

  // store access and handshake outputs
  always_comb begin
    wr.en   = (state_r == ST_PUT) && put_ok;
    wr.pos  = wp_r;
    wr.data = put_byte;
    rd_addr = issue_w_r;
    busy    = state_r != ST_IDLE;
  end

  assign out_valid      = out_valid_r;
  assign out_frame_data = out_data_r;
  assign out_byte_count = out_cnt_r;
  assign out_last_word  = out_last_r;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wp_r        <= '0;
      chk_r       <= CHECK_SEED;
      ovf_r       <= 1'b0;
      scnt_r      <= '0;
      scap_r      <= 1'b0;
      put_cnt_r   <= '0;
      hdr_r       <= 1'b0;
      issue_w_r   <= '0;
      data_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      chk_r       <= chk_nxt;
      ovf_r       <= ovf_nxt;
      scnt_r      <= scnt_nxt;
      scap_r      <= scap_nxt;
      put_cnt_r   <= put_cnt_nxt;
      hdr_r       <= hdr_nxt;
      issue_w_r   <= issue_w_nxt;
      data_v_r    <= state_r == ST_EMIT;
      out_valid_r <= data_v_r;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    put_data_r <= put_data_nxt;
    data_w_r   <= issue_w_r;
    out_data_r <= out_data_nxt;
    out_cnt_r  <= out_cnt_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule

`default_nettype wire

### tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import lrf_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 32;
  localparam logic [CFG_AW-1:0] MAX_STR_ADDR = {REG_MAX_STR, 2'b00};

  typedef struct {
    op_t         op;
    logic [15:0] file_id;
    logic [15:0] line_number;
    logic [63:0] value;
    logic [1:0]  value_size;
    logic [7:0]  text_char;
  } log_cmd_t;

  typedef struct {
    logic [63:0] data;
    logic [3:0]  count;
    logic        last;
  } frame_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_operation = '0;
  logic [15:0] in_file_id = '0;
  logic [15:0] in_line_number = '0;
  logic [63:0] in_value = '0;
  logic [1:0] in_value_size = '0;
  logic [7:0] in_text_char = '0;
  logic out_valid;
  logic [63:0] out_frame_data;
  logic [3:0] out_byte_count;
  logic out_last_word;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  // pending commands and frame words still owed by the block
  log_cmd_t cmd_q[$];
  frame_word_t frame_words_due[$];
  log_cmd_t held_cmd;
  int gap_left = 0;
  int burst_left = 0;
  int mismatch_count = 0;
  int stall_cycles = 0;

  // predicted record state
  logic [7:0] rec_bytes [STORE_DEPTH];
  logic [POS_W-1:0] rec_wpos = '0;
  logic [7:0] rec_check = CHECK_SEED;
  logic rec_ovf = 1'b0;
  logic [7:0] str_count = '0;
  logic str_capped = 1'b0;
  logic [7:0] str_max = STR_RESET_LEN;

  always #5 clk = ~clk;

  log_record_framer_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_operation   (in_operation),
    .in_file_id     (in_file_id),
    .in_line_number (in_line_number),
    .in_value       (in_value),
    .in_value_size  (in_value_size),
    .in_text_char   (in_text_char),
    .out_valid      (out_valid),
    .out_frame_data (out_frame_data),
    .out_byte_count (out_byte_count),
    .out_last_word  (out_last_word),
    .cfg_psel       (cfg_psel),
    .cfg_penable    (cfg_penable),
    .cfg_pwrite     (cfg_pwrite),
    .cfg_paddr      (cfg_paddr),
    .cfg_pwdata     (cfg_pwdata),
    .cfg_prdata     (cfg_prdata),
    .cfg_pready     (cfg_pready)
  );

  task automatic report_mismatch(string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // ---------------- record predictor ----------------

  function automatic void store_byte(logic [7:0] b);
    if (rec_wpos < PUT_LIMIT) begin
      rec_bytes[rec_wpos] = b;
      rec_check = rec_check ^ b;
      rec_wpos = rec_wpos + 1'b1;
    end else begin
      rec_ovf = 1'b1;
    end
  endfunction

  // patch length byte, append check and split into words
  function automatic void queue_frame_words();
    logic [7:0] len;
    logic [7:0] chk;
    int total;
    int words;
    int idx;
    frame_word_t fw;
    len = 8'(rec_wpos) - HDR_LEN_OFS;
    if (rec_ovf) len = len | OVF_BIT;
    rec_bytes[LEN_POS] = len;
    chk = rec_check ^ len;
    total = int'(rec_wpos) + 1;
    words = (total + 7) / 8;
    for (int w = 0; w < words; w++) begin
      fw.data = '0;
      fw.count = '0;
      for (int k = 0; k < 8; k++) begin
        idx = w * 8 + k;
        if (idx < total) begin
          fw.data[8*k +: 8] = (idx == int'(rec_wpos)) ? chk : rec_bytes[POS_W'(idx)];
          fw.count = fw.count + 1'b1;
        end
      end
      fw.last = (w == words - 1);
      frame_words_due.push_back(fw);
    end
  endfunction

  function automatic void advance_record(log_cmd_t c);
    int nbytes;
    case (c.op)
      OP_START: begin
        rec_wpos = '0;
        rec_check = CHECK_SEED;
        rec_ovf = 1'b0;
        str_count = '0;
        str_capped = 1'b0;
        store_byte(HDR_MARK);
        store_byte(c.file_id[7:0]);
        store_byte(c.file_id[15:8]);
        store_byte(c.line_number[7:0]);
        store_byte(c.line_number[15:8]);
        rec_wpos = rec_wpos + 1'b1;
      end
      OP_VALUE: begin
        nbytes = 1 << c.value_size;
        for (int i = 0; i < nbytes; i++) store_byte(c.value[8*i +: 8]);
      end
      OP_STRING: begin
        if (str_capped) begin
          // swallow characters until the terminator
          if (c.text_char == 8'd0) begin
            str_capped = 1'b0;
            str_count = '0;
          end
        end else if (c.text_char == 8'd0) begin
          store_byte(8'd0);
          str_count = '0;
        end else begin
          if (str_count < str_max) begin
            store_byte(c.text_char);
            str_count = str_count + 1'b1;
          end
          if (str_count >= str_max) begin
            store_byte(8'd0);
            str_capped = 1'b1;
          end
        end
      end
      default: queue_frame_words();
    endcase
  endfunction

  // ---------------- command generation ----------------

  function automatic log_cmd_t noise_cmd();
    log_cmd_t c;
    c.op = op_t'($urandom_range(0, 3));
    c.file_id = 16'($urandom());
    c.line_number = 16'($urandom());
    c.value = {$urandom(), $urandom()};
    c.value_size = 2'($urandom_range(0, 3));
    c.text_char = 8'($urandom());
    return c;
  endfunction

  function automatic void push_start(logic [15:0] fid, logic [15:0] line);
    log_cmd_t c;
    c = noise_cmd();
    c.op = OP_START;
    c.file_id = fid;
    c.line_number = line;
    cmd_q.push_back(c);
  endfunction

  function automatic void push_value(logic [63:0] v, logic [1:0] size);
    log_cmd_t c;
    c = noise_cmd();
    c.op = OP_VALUE;
    c.value = v;
    c.value_size = size;
    cmd_q.push_back(c);
  endfunction

  function automatic void push_char(logic [7:0] ch);
    log_cmd_t c;
    c = noise_cmd();
    c.op = OP_STRING;
    c.text_char = ch;
    cmd_q.push_back(c);
  endfunction

  function automatic void push_end();
    log_cmd_t c;
    c = noise_cmd();
    c.op = OP_END;
    cmd_q.push_back(c);
  endfunction

  function automatic logic [63:0] pick_value();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return 64'd1 << $urandom_range(0, 63);
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  function automatic logic [15:0] pick_header_field();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom());
    endcase
  endfunction

  // one well-formed record with random content, sometimes broken
  function automatic void push_random_record();
    int parts;
    int len;
    int r;
    push_start(pick_header_field(), pick_header_field());
    if ($urandom_range(0, 9) == 0) begin
      // enough eight-byte values to run past the payload limit
      repeat ($urandom_range(13, 16)) push_value(pick_value(), 2'd3);
    end else begin
      parts = $urandom_range(0, 8);
      repeat (parts) begin
        r = $urandom_range(0, 99);
        if (r < 45) begin
          push_value(pick_value(), 2'($urandom_range(0, 3)));
        end else if (r < 80) begin
          len = (int'(str_max) + 2 < 12) ? int'(str_max) + 2 : 12;
          len = $urandom_range(0, len);
          repeat (len) push_char(8'($urandom_range(1, 255)));
          if ($urandom_range(0, 4) != 0) push_char(8'd0);
        end else if (r < 90) begin
          push_char(8'd0);
        end else begin
          cmd_q.push_back(noise_cmd());
        end
      end
    end
    push_end();
    r = $urandom_range(0, 99);
    if (r < 15) begin
      push_end();
    end else if (r < 25) begin
      push_value(pick_value(), 2'($urandom_range(0, 3)));
      push_end();
    end
  endfunction

  task automatic run_random_phase(int target);
    int n;
    n = 0;
    while (n < target) begin
      n = n - cmd_q.size();
      if ($urandom_range(0, 99) < 8) cmd_q.push_back(noise_cmd());
      push_random_record();
      n = n + cmd_q.size();
    end
  endtask

  // ---------------- driver ----------------

  function automatic int next_gap();
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      burst_left = $urandom_range(10, 40);
      return 0;
    end
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // present words from cmd_q, predicting each one as it is taken
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) advance_record(held_cmd);
      if (start && busy) begin
        // hold the word until the block takes it
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (cmd_q.size() > 0) begin
        held_cmd = cmd_q.pop_front();
        in_operation <= held_cmd.op;
        in_file_id <= held_cmd.file_id;
        in_line_number <= held_cmd.line_number;
        in_value <= held_cmd.value;
        in_value_size <= held_cmd.value_size;
        in_text_char <= held_cmd.text_char;
        start <= 1'b1;
        gap_left <= next_gap();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // ---------------- monitor ----------------

  always @(posedge clk) begin
    frame_word_t e;
    if (rst_n && out_valid) begin
      if (frame_words_due.size() == 0) begin
        report_mismatch($sformatf("unexpected frame word data=%h count=%0d last=%b",
                                  out_frame_data, out_byte_count, out_last_word));
      end else begin
        e = frame_words_due.pop_front();
        if (out_frame_data !== e.data)
          report_mismatch($sformatf("frame_data got %h exp %h", out_frame_data, e.data));
        if (out_byte_count !== e.count)
          report_mismatch($sformatf("byte_count got %0d exp %0d", out_byte_count, e.count));
        if (out_last_word !== e.last)
          report_mismatch($sformatf("last_word got %b exp %b", out_last_word, e.last));
      end
    end
  end

  // ---------------- watchdog ----------------

  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_psel && cfg_penable && cfg_pready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout: no activity for %0d cycles", STALL_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---------------- configuration ----------------

  task automatic apb_access(logic wr, logic [31:0] wdata, output logic [31:0] rdata);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= wr;
    cfg_paddr <= MAX_STR_ADDR;
    cfg_pwdata <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  // write the string cap, then read it back
  task automatic set_max_string(logic [7:0] len);
    logic [31:0] rd;
    apb_access(1'b1, {24'($urandom()), len}, rd);
    str_max = len;
    apb_access(1'b0, 32'($urandom()), rd);
    if (rd[7:0] !== len)
      report_mismatch($sformatf("max_string_length read %h exp %h", rd[7:0], len));
  endtask

  task automatic wait_idle();
    while (cmd_q.size() != 0 || start || frame_words_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------- stimulus ----------------

  initial begin
    // header extremes, every value size, a short string and a repeated end
    push_start(16'h0000, 16'h0000);
    push_value(64'h0, 2'd0);
    push_value('1, 2'd3);
    push_value(64'h8001, 2'd1);
    push_value(64'hDEAD_BEEF_8765_4321, 2'd2);
    push_char(8'h68);
    push_char(8'hFF);
    push_char(8'h00);
    push_end();
    push_end();
    // empty payload
    push_start(16'hFFFF, 16'hFFFF);
    push_end();

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    wait_idle();

    // cap of one: second character ignored, terminator clears the cap
    set_max_string(8'd1);
    push_start(16'h1234, 16'h5678);
    push_char(8'h61);
    push_char(8'h62);
    push_char(8'h00);
    push_char(8'h00);
    push_end();
    wait_idle();

    // zero cap: any character just forces the terminator
    set_max_string(8'd0);
    push_start(16'hA55A, 16'h0F0F);
    push_char(8'h78);
    push_char(8'h00);
    push_end();
    wait_idle();

    set_max_string(8'd255);
    run_random_phase(72);
    wait_idle();
    set_max_string(8'd3);
    run_random_phase(72);
    wait_idle();
    set_max_string(8'($urandom_range(1, 255)));
    run_random_phase(72);
    wait_idle();
    set_max_string(8'd1);
    run_random_phase(72);
    wait_idle();
    set_max_string(8'd32);
    run_random_phase(72);
    wait_idle();

    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
